[hw/rtl/acops_pkg.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// acops_pkg: shared types and codes of the pheromone step unit
// Table sizes, request codes, register indexes and the result word.
// ----------------------------------------------------------------------------
package acops_pkg;
	// table sizes
	localparam int MAX_LOCATIONS  = 64;
	localparam int MAX_NEIGHBOURS = 16;

	typedef enum logic [2:0] {
		REQ_LOAD_HEUR  = 3'd0,
		REQ_LOAD_NBR   = 3'd1,
		REQ_INIT_PHER  = 3'd2,
		REQ_START_ANT  = 3'd3,
		REQ_STEP       = 3'd4,
		REQ_EVAPORATE  = 3'd5,
		REQ_DEPOSIT    = 3'd6,
		REQ_UNUSED     = 3'd7
	} req_t;

	localparam logic [2:0] CFG_LOC_COUNT = 3'd0;
	localparam logic [2:0] CFG_START     = 3'd1;
	localparam logic [2:0] CFG_FINISH    = 3'd2;
	localparam logic [2:0] CFG_NBR_COUNT = 3'd3;
	localparam logic [2:0] CFG_TAU_MAX   = 3'd4;
	localparam logic [2:0] CFG_TAU_MIN   = 3'd5;
	localparam logic [2:0] CFG_RETAIN    = 3'd6;

	// result word handed from the core to the output stage
	typedef struct packed {
		logic [5:0] next_location;
		logic       ant_done;
		logic       used_fallback;
	} result_t;
endpackage
`default_nettype wire

[hw/rtl/acops_if.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// acops_if: valid/ready channels of the pheromone step unit
// Request, result and configuration write channels.
// ----------------------------------------------------------------------------
interface acops_req_if;
	logic        valid;
	logic        ready;
	logic [2:0]  req_type;
	logic [5:0]  row;
	logic [5:0]  col;
	logic [31:0] value;
	logic [15:0] random_fraction;
	modport source (output valid, req_type, row, col, value, random_fraction, input ready);
	modport sink (input valid, req_type, row, col, value, random_fraction, output ready);
endinterface

interface acops_res_if;
	logic       valid;
	logic       ready;
	logic [5:0] next_location;
	logic       ant_done;
	logic       used_fallback;
	modport source (output valid, next_location, ant_done, used_fallback, input ready);
	modport sink (input valid, next_location, ant_done, used_fallback, output ready);
endinterface

interface acops_cfg_if;
	logic        valid;
	logic        ready;
	logic [2:0]  index;
	logic [31:0] data;
	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface
`default_nettype wire

[hw/rtl/ant_colony_pheromone_step_unit.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// ant_colony_pheromone_step_unit: max-min ant system core
// Evaporation reads, scales and writes back each entry in turn. A step makes
// a sum pass over the neighbour slots, then a roulette pass over them or,
// when no neighbour is a candidate, a fallback pass over the locations that
// keeps the heaviest edge. One shared multiplier forms the edge weights, the
// evaporated values and the roulette threshold.
// Throughput: one request at a time; the next request is accepted while the
// result waits, and only the done state stalls on a full output register.
// Reset: registers take their defaults, ant cleared; tables undefined.
// ----------------------------------------------------------------------------
module ant_colony_pheromone_step_unit
	import acops_pkg::*;
(
	input  wire logic   clk,
	input  wire logic   arst_n,
	acops_req_if.sink   req,
	acops_res_if.source res,
	acops_cfg_if.sink   cfg
);
	localparam int LW  = $clog2(MAX_LOCATIONS);
	localparam int NW  = (MAX_NEIGHBOURS > 1) ? $clog2(MAX_NEIGHBOURS) : 1;
	localparam int AW  = 2 * LW;
	localparam int NBA = LW + NW;
	localparam int DEPTH = MAX_LOCATIONS * MAX_LOCATIONS;

	typedef enum logic [11:0] {
		S_IDLE   = 12'b000000000001,
		S_EXEC   = 12'b000000000010,
		S_SLOT   = 12'b000000000100,
		S_SLOTW  = 12'b000000001000,
		S_WRD    = 12'b000000010000,
		S_WMUL   = 12'b000000100000,
		S_PICK   = 12'b000001000000,
		S_PICKW  = 12'b000010000000,
		S_EVRD   = 12'b000100000000,
		S_EVMUL  = 12'b001000000000,
		S_EVWR   = 12'b010000000000,
		S_DONE   = 12'b100000000000
	} state_t;

	state_t state_q;

	// configuration registers
	logic [6:0]  loc_count_q;
	logic [5:0]  start_q, finish_q;
	logic [4:0]  nbr_count_q;
	logic [31:0] tau_max_q, tau_min_q;
	logic [15:0] retain_q;

	// latched request
	req_t        op_q;
	logic [5:0]  row_q, col_q;
	logic [31:0] val_q;
	logic [15:0] rnd_q;

	// ant state
	logic [MAX_LOCATIONS-1:0] visited_q;
	logic [LW-1:0]            cur_q;

	// memories
	logic [31:0] pher_mem [DEPTH];
	logic [31:0] heur_mem [DEPTH];
	logic [5:0]  nbr_mem  [MAX_LOCATIONS*MAX_NEIGHBOURS];
	logic [31:0] pher_rd_q, heur_rd_q;
	logic [5:0]  nbr_rd_q;
	logic        pher_we, heur_we, nbr_we;
	logic [AW-1:0]  pher_wa, pher_ra, heur_wa;
	logic [NBA-1:0] nbr_ra, nbr_wa;
	logic [31:0] pher_wd;

	// sequencer working registers
	logic [AW:0]  idx_q;
	logic         pass_q;     // 0 scan/sum pass, 1 roulette pass
	logic         fb_q;       // fallback scan active
	logic [LW-1:0] loc_q;
	logic         loc_ok_q;
	logic [63:0]  prod_q;
	logic [37:0]  sum_q, acc_q;
	logic [53:0]  thr_q;
	logic [31:0]  best_q;
	logic [LW-1:0] next_q, last_q;
	logic         any_q;
	result_t      out_q;
	logic         out_valid_q;

	// one shared 32x32 multiplier
	logic [31:0] mul_a, mul_b;
	logic [63:0] mul_p;
	assign mul_p = {32'd0, mul_a} * {32'd0, mul_b};

	logic [6:0] eff_n;
	logic [6:0] eff_slots;
	assign eff_n = (loc_count_q > 7'(MAX_LOCATIONS)) ? 7'(MAX_LOCATIONS) : loc_count_q;
	assign eff_slots = (32'(nbr_count_q) > MAX_NEIGHBOURS) ? 7'(MAX_NEIGHBOURS)
		: {2'b00, nbr_count_q};

	logic req_fire, idle;
	assign idle = state_q == S_IDLE;
	assign req.ready = idle;
	assign req_fire = req.valid && req.ready;
	assign cfg.ready = 1'b1;
	assign res.valid = out_valid_q;
	assign res.next_location = out_q.next_location;
	assign res.ant_done = out_q.ant_done;
	assign res.used_fallback = out_q.used_fallback;

	logic row_ok, col_ok, slot_ok;
	assign row_ok = 32'(row_q) < MAX_LOCATIONS;
	assign col_ok = 32'(col_q) < MAX_LOCATIONS;
	assign slot_ok = 32'(col_q) < MAX_NEIGHBOURS;

	// candidate test for the location just read
	logic [LW-1:0] cand;
	logic          cand_ok;
	always_comb begin
		cand = fb_q ? idx_q[LW-1:0] : nbr_rd_q[LW-1:0];
		cand_ok = !visited_q[cand] && (7'(cand) != {1'b0, finish_q})
			&& (fb_q || ({1'b0, nbr_rd_q} < eff_n));
		if (!fb_q && 32'(nbr_rd_q) >= MAX_LOCATIONS) cand_ok = 1'b0;
	end

	// memory address and write selection
	always_comb begin
		pher_we = 1'b0;
		heur_we = 1'b0;
		nbr_we  = 1'b0;
		pher_wa = {row_q[LW-1:0], col_q[LW-1:0]};
		pher_ra = {cur_q, loc_q};
		heur_wa = {row_q[LW-1:0], col_q[LW-1:0]};
		nbr_wa  = {row_q[LW-1:0], col_q[NW-1:0]};
		nbr_ra  = {cur_q, idx_q[NW-1:0]};
		pher_wd = tau_max_q;
		mul_a = pher_rd_q;
		mul_b = heur_rd_q;
		case (state_q)
			S_EXEC: begin
				if (op_q == REQ_LOAD_HEUR && row_ok && col_ok) heur_we = 1'b1;
				if (op_q == REQ_LOAD_NBR && row_ok && slot_ok) nbr_we = 1'b1;
				if (op_q == REQ_INIT_PHER) begin
					pher_we = 1'b1;
					pher_wa = idx_q[AW-1:0];
				end
				pher_ra = {row_q[LW-1:0], col_q[LW-1:0]};
			end
			S_EVRD: pher_ra = idx_q[AW-1:0];
			S_EVMUL: begin
				mul_b = {16'd0, retain_q};
			end
			S_EVWR: begin
				pher_we = 1'b1;
				pher_wa = idx_q[AW-1:0];
				pher_wd = (prod_q[47:16] < tau_min_q) ? tau_min_q : prod_q[47:16];
			end
			S_WRD: begin
				if (op_q == REQ_DEPOSIT) begin
					pher_we = row_ok && col_ok;
					pher_wd = ({1'b0, pher_rd_q} + {1'b0, val_q} > {1'b0, tau_max_q})
						? tau_max_q : pher_rd_q + val_q;
				end
			end
			// threshold in two halves: low 32 bits of the sum, then the rest
			S_PICK: begin
				mul_a = {16'd0, rnd_q};
				mul_b = sum_q[31:0];
			end
			S_PICKW: begin
				mul_a = {16'd0, rnd_q};
				mul_b = {26'd0, sum_q[37:32]};
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk) begin
		if (pher_we) pher_mem[pher_wa] <= pher_wd;
		if (heur_we) heur_mem[heur_wa] <= val_q;
		if (nbr_we) nbr_mem[nbr_wa] <= val_q[5:0];
		pher_rd_q <= pher_mem[pher_ra];
		heur_rd_q <= heur_mem[pher_ra];
		nbr_rd_q  <= nbr_mem[nbr_ra];
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			loc_count_q <= 7'd64;
			start_q <= 6'd0;
			finish_q <= 6'd1;
			nbr_count_q <= 5'd8;
			tau_max_q <= 32'd65536;
			tau_min_q <= 32'd655;
			retain_q <= 16'd52429;
			visited_q <= '0;
			cur_q <= '0;
			out_valid_q <= 1'b0;
			idx_q <= '0;
		end else begin
			if (cfg.valid) begin
				unique case (cfg.index)
					CFG_LOC_COUNT: loc_count_q <= cfg.data[6:0];
					CFG_START:     start_q <= cfg.data[5:0];
					CFG_FINISH:    finish_q <= cfg.data[5:0];
					CFG_NBR_COUNT: nbr_count_q <= cfg.data[4:0];
					CFG_TAU_MAX:   tau_max_q <= cfg.data;
					CFG_TAU_MIN:   tau_min_q <= cfg.data;
					CFG_RETAIN:    retain_q <= cfg.data[15:0];
					default: ;
				endcase
			end
			if (res.valid && res.ready && state_q != S_DONE) out_valid_q <= 1'b0;
			unique case (state_q)
				S_IDLE: begin
					if (req_fire) begin
						op_q <= req_t'(req.req_type);
						row_q <= req.row;
						col_q <= req.col;
						val_q <= req.value;
						rnd_q <= req.random_fraction;
						idx_q <= '0;
						state_q <= S_EXEC;
					end
				end
				S_EXEC: begin
					unique case (op_q)
						REQ_INIT_PHER: begin
							idx_q <= idx_q + 1'b1;
							if (idx_q[AW-1:0] == AW'(DEPTH - 1)) state_q <= S_DONE;
						end
						REQ_START_ANT: begin
							cur_q <= (32'(start_q) < MAX_LOCATIONS) ? start_q[LW-1:0] : '0;
							visited_q <= MAX_LOCATIONS'(1) <<
								((32'(start_q) < MAX_LOCATIONS) ? start_q[LW-1:0] : '0);
							state_q <= S_DONE;
						end
						REQ_STEP: begin
							pass_q <= 1'b0;
							fb_q <= 1'b0;
							sum_q <= '0;
							acc_q <= '0;
							best_q <= '0;
							any_q <= 1'b0;
							next_q <= cur_q;
							state_q <= S_SLOT;
						end
						REQ_EVAPORATE: state_q <= S_EVRD;
						REQ_DEPOSIT: state_q <= S_WRD;
						default: state_q <= S_DONE;
					endcase
				end
				// issue neighbour list read (or fallback index)
				S_SLOT: begin
					if (!fb_q && idx_q >= (AW+1)'(eff_slots)) begin
						if (!pass_q && any_q) begin
							state_q <= S_PICK;
						end else if (!pass_q) begin
							fb_q <= 1'b1;
							idx_q <= '0;
						end else begin
							// no running sum exceeded: last candidate
							next_q <= last_q;
							state_q <= S_DONE;
						end
					end else if (fb_q && idx_q >= (AW+1)'(eff_n)) begin
						state_q <= S_DONE;
					end else begin
						state_q <= S_SLOTW;
					end
				end
				S_SLOTW: begin
					loc_q <= cand;
					loc_ok_q <= cand_ok;
					state_q <= S_WRD;
				end
				S_WRD: begin
					if (op_q == REQ_DEPOSIT) begin
						state_q <= S_DONE;
					end else if (!loc_ok_q) begin
						idx_q <= idx_q + 1'b1;
						state_q <= S_SLOT;
					end else begin
						state_q <= S_WMUL;
					end
				end
				// weight in, then accumulate, test or compare
				S_WMUL: begin
					idx_q <= idx_q + 1'b1;
					state_q <= S_SLOT;
					if (fb_q) begin
						if (mul_p[63:32] > best_q) begin
							best_q <= mul_p[63:32];
							next_q <= loc_q;
						end
					end else if (!pass_q) begin
						sum_q <= sum_q + 38'(mul_p[63:32]);
						any_q <= 1'b1;
					end else begin
						acc_q <= acc_q + 38'(mul_p[63:32]);
						last_q <= loc_q;
						if ({thr_q} < 54'({acc_q + 38'(mul_p[63:32]), 16'd0})) begin
							next_q <= loc_q;
							state_q <= S_DONE;
						end
					end
				end
				S_PICK: begin
					prod_q <= mul_p;
					state_q <= S_PICKW;
				end
				S_PICKW: begin
					thr_q <= 54'(prod_q[47:0]) + {mul_p[21:0], 32'd0};
					pass_q <= 1'b1;
					idx_q <= '0;
					state_q <= S_SLOT;
				end
				S_EVRD: state_q <= S_EVMUL;
				S_EVMUL: begin
					prod_q <= mul_p;
					state_q <= S_EVWR;
				end
				S_EVWR: begin
					idx_q <= idx_q + 1'b1;
					state_q <= (idx_q[AW-1:0] == AW'(DEPTH - 1)) ? S_DONE : S_EVRD;
				end
				// hold until the output register is free, then load the word
				S_DONE: begin
					if (!out_valid_q || res.ready) begin
						out_valid_q <= 1'b1;
						state_q <= S_IDLE;
						out_q.ant_done <= 1'b0;
						out_q.used_fallback <= 1'b0;
						if (op_q == REQ_STEP) begin
							out_q.used_fallback <= fb_q;
							if (next_q == cur_q) begin
								out_q.ant_done <= 1'b1;
								out_q.next_location <= 6'(cur_q);
							end else begin
								cur_q <= next_q;
								visited_q[next_q] <= 1'b1;
								out_q.next_location <= 6'(next_q);
							end
						end else begin
							out_q.next_location <= 6'(cur_q);
						end
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

`ifndef SYNTH
	// a waiting result word holds its fields
	a_res_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(res.valid && !res.ready) |=> (res.valid && $stable(out_q)))
		else $error("result changed while waiting");
	// a result only rises from the done state
	a_res_from_done: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(state_q == S_DONE)) else $error("stray result");
	// requests are taken only while idle
	a_accept_idle: assert property (@(posedge clk) disable iff (!arst_n)
		req.ready |-> (state_q == S_IDLE)) else $error("accept while busy");
	// the sequencer state stays one-hot
	a_state_onehot: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot(state_q)) else $error("state not one-hot");
`endif
endmodule
`default_nettype wire

[verif/tb_ant_colony_pheromone_step_unit.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// tb_ant_colony_pheromone_step_unit: self-checking bench of the ant system core
// Loads the tables of the locations in use, runs a short table of directed
// requests, then several phases of random ant tours, each under its own
// register setting and a per-phase mix of sender and receiver idling. Every
// result word is compared with a fixed answer (some directed requests) or an
// in-bench predictor of the pheromone, heuristic, neighbour tables and the ant.
// ----------------------------------------------------------------------------
module tb_ant_colony_pheromone_step_unit;
	import acops_pkg::*;

	localparam int LOCS        = 64;
	localparam int SLOTS       = 16;
	localparam int USED_LOCS   = 16;
	localparam int PHASES      = 5;
	localparam int PHASE_WORDS = 112;
	localparam int STALL_LIMIT = 100000;

	typedef struct {
		req_t        kind;
		logic [5:0]  row;
		logic [5:0]  col;
		logic [31:0] value;
		logic [15:0] rnd;
		bit          typed;
		result_t     typed_res;
	} request_t;

	logic clk;
	logic arst_n;

	acops_req_if req_ch ();
	acops_res_if res_ch ();
	acops_cfg_if cfg_ch ();

	ant_colony_pheromone_step_unit i_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req_ch),
		.res    (res_ch),
		.cfg    (cfg_ch)
	);

	// predictor state
	logic [31:0] pher_tab [LOCS*LOCS];
	logic [31:0] heur_tab [LOCS*LOCS];
	logic [5:0]  nbr_tab  [LOCS*SLOTS];
	logic [63:0] visited;
	logic [5:0]  cur_loc;
	logic [6:0]  loc_count;
	logic [5:0]  start_loc;
	logic [5:0]  finish_loc;
	logic [4:0]  nbr_count;
	logic [31:0] tau_max;
	logic [31:0] tau_min;
	logic [15:0] retain;

	result_t pending_results [$];
	int      errors;
	int      stall_cycles;
	int      tx_idle;
	int      rx_idle;
	request_t cur_req;

	initial clk = 1'b0;
	always #5 clk = ~clk;

	function automatic logic [63:0] edge_weight(logic [5:0] from, logic [5:0] to);
		int k;
		k = int'(from) * LOCS + int'(to);
		return (64'(pher_tab[k]) * 64'(heur_tab[k])) >> 32;
	endfunction

	// advance the ant by one location: roulette over neighbours, else argmax
	function automatic result_t predict_step(logic [15:0] rnd);
		result_t     r;
		logic [5:0]  cand [SLOTS];
		logic [63:0] wt [SLOTS];
		logic [63:0] sum, thr, acc, best, w;
		logic [5:0]  loc, nxt;
		int          n, slots, nc, pick;
		n = (loc_count > LOCS) ? LOCS : int'(loc_count);
		slots = (nbr_count > SLOTS) ? SLOTS : int'(nbr_count);
		nc = 0;
		sum = 0;
		nxt = cur_loc;
		r.used_fallback = 1'b0;
		for (int s = 0; s < slots; s++) begin
			loc = nbr_tab[int'(cur_loc) * SLOTS + s];
			if (int'(loc) >= n || loc == finish_loc || visited[loc])
				continue;
			cand[nc] = loc;
			wt[nc] = edge_weight(cur_loc, loc);
			sum += wt[nc];
			nc++;
		end
		if (nc > 0) begin
			thr = 64'(rnd) * sum;
			acc = 0;
			pick = nc - 1;
			for (int s = 0; s < nc; s++) begin
				acc += wt[s];
				if (thr < (acc << 16)) begin
					pick = s;
					break;
				end
			end
			nxt = cand[pick];
		end else begin
			r.used_fallback = 1'b1;
			best = 0;
			for (int i = 0; i < n; i++) begin
				if (6'(i) == finish_loc || visited[i])
					continue;
				w = edge_weight(cur_loc, 6'(i));
				if (w > best) begin
					best = w;
					nxt = 6'(i);
				end
			end
		end
		r.ant_done = (nxt == cur_loc);
		if (!r.ant_done) begin
			visited[nxt] = 1'b1;
			cur_loc = nxt;
		end
		r.next_location = cur_loc;
		return r;
	endfunction

	function automatic result_t predict_request(request_t it);
		result_t     r;
		logic [32:0] dep;
		logic [31:0] v;
		int          k;
		r = '0;
		k = int'(it.row) * LOCS + int'(it.col);
		case (it.kind)
			REQ_LOAD_HEUR: heur_tab[k] = it.value;
			REQ_LOAD_NBR: begin
				if (it.col < SLOTS)
					nbr_tab[int'(it.row) * SLOTS + int'(it.col)] = it.value[5:0];
			end
			REQ_INIT_PHER: begin
				for (int i = 0; i < LOCS*LOCS; i++)
					pher_tab[i] = tau_max;
			end
			REQ_START_ANT: begin
				visited = '0;
				cur_loc = start_loc;
				visited[cur_loc] = 1'b1;
			end
			REQ_STEP: r = predict_step(it.rnd);
			REQ_EVAPORATE: begin
				for (int i = 0; i < LOCS*LOCS; i++) begin
					v = 32'((64'(pher_tab[i]) * 64'(retain)) >> 16);
					pher_tab[i] = (v < tau_min) ? tau_min : v;
				end
			end
			REQ_DEPOSIT: begin
				dep = 33'(pher_tab[k]) + 33'(it.value);
				pher_tab[k] = (dep > 33'(tau_max)) ? tau_max : dep[31:0];
			end
			default: ;
		endcase
		r.next_location = cur_loc;
		return r;
	endfunction

	task automatic report(string what, logic [31:0] got, logic [31:0] want);
		$display("mismatch %s: got %0d, want %0d", what, got, want);
		errors++;
	endtask

	// offer one word, starting and ending at a falling edge; valid stays high
	task automatic send(request_t it);
		while ($urandom_range(99) < tx_idle) begin
			req_ch.valid <= 1'b0;
			@(negedge clk);
		end
		cur_req = it;
		req_ch.valid <= 1'b1;
		req_ch.req_type <= it.kind;
		req_ch.row <= it.row;
		req_ch.col <= it.col;
		req_ch.value <= it.value;
		req_ch.random_fraction <= it.rnd;
		do @(posedge clk); while (!req_ch.ready);
		@(negedge clk);
	endtask

	task automatic drain();
		req_ch.valid <= 1'b0;
		while (pending_results.size() != 0)
			@(posedge clk);
		repeat (4) @(negedge clk);
	endtask

	task automatic write_reg(logic [2:0] idx, logic [31:0] data);
		cfg_ch.valid <= 1'b1;
		cfg_ch.index <= idx;
		cfg_ch.data <= data;
		do @(posedge clk); while (!cfg_ch.ready);
		case (idx)
			CFG_LOC_COUNT: loc_count = data[6:0];
			CFG_START:     start_loc = data[5:0];
			CFG_FINISH:    finish_loc = data[5:0];
			CFG_NBR_COUNT: nbr_count = data[4:0];
			CFG_TAU_MAX:   tau_max = data;
			CFG_TAU_MIN:   tau_min = data;
			CFG_RETAIN:    retain = data[15:0];
			default: ;
		endcase
		@(negedge clk);
	endtask

	function automatic request_t mk(req_t kind, logic [5:0] row, logic [5:0] col,
			logic [31:0] value, logic [15:0] rnd);
		request_t it;
		it.kind = kind;
		it.row = row;
		it.col = col;
		it.value = value;
		it.rnd = rnd;
		it.typed = 1'b0;
		it.typed_res = '0;
		return it;
	endfunction

	function automatic request_t random_request();
		request_t it;
		int       pick;
		int       n;
		pick = $urandom_range(99);
		n = (loc_count > LOCS) ? LOCS : ((loc_count == 0) ? 1 : int'(loc_count));
		it = mk(REQ_STEP, 6'($urandom), 6'($urandom), $urandom, 16'($urandom));
		if (pick < 8)
			it.kind = REQ_START_ANT;
		else if (pick < 60)
			it.kind = REQ_STEP;
		else if (pick < 70) begin
			it.kind = REQ_DEPOSIT;
			if ($urandom_range(3) == 0)
				it.value = 32'($urandom_range(0, 131072));
		end else if (pick < 78)
			it.kind = REQ_LOAD_HEUR;
		else if (pick < 86) begin
			it.kind = REQ_LOAD_NBR;
			it.col = 6'($urandom_range(0, 31));
			if ($urandom_range(3) != 0)
				it.value[5:0] = 6'($urandom_range(0, n - 1));
		end else if (pick < 88)
			it.kind = REQ_INIT_PHER;
		else if (pick < 89)
			it.kind = REQ_EVAPORATE;
		else if (pick < 92)
			it.kind = REQ_UNUSED;
		return it;
	endfunction

	// predict on every accepted request word
	always @(posedge clk) begin
		result_t exp_word;
		if (arst_n && req_ch.valid && req_ch.ready) begin
			if (cur_req.typed) begin
				void'(predict_request(cur_req));
				exp_word = cur_req.typed_res;
			end else
				exp_word = predict_request(cur_req);
			pending_results = {pending_results, exp_word};
		end
	end

	// check every accepted result word against the oldest expectation
	always @(posedge clk) begin
		result_t want;
		if (arst_n && res_ch.valid && res_ch.ready) begin
			if (pending_results.size() == 0) begin
				report("unexpected result word", 32'(res_ch.next_location), 32'd0);
			end else begin
				want = pending_results.pop_front();
				if (res_ch.next_location !== want.next_location)
					report("next_location", 32'(res_ch.next_location), 32'(want.next_location));
				if (res_ch.ant_done !== want.ant_done)
					report("ant_done", 32'(res_ch.ant_done), 32'(want.ant_done));
				if (res_ch.used_fallback !== want.used_fallback)
					report("used_fallback", 32'(res_ch.used_fallback),
						32'(want.used_fallback));
			end
		end
	end

	// randomize result back-pressure
	always @(negedge clk)
		res_ch.ready <= ($urandom_range(99) >= rx_idle);

	// stop a hung run
	always @(posedge clk) begin
		if ((req_ch.valid && req_ch.ready) || (res_ch.valid && res_ch.ready)
				|| (cfg_ch.valid && cfg_ch.ready))
			stall_cycles <= 0;
		else if (stall_cycles >= STALL_LIMIT) begin
			$display("tb_ant_colony_pheromone_step_unit: errors");
			$finish;
		end else
			stall_cycles <= stall_cycles + 1;
	end

	initial begin
		request_t    directed [$];
		request_t    it;
		logic [31:0] regs [PHASES][7];

		arst_n = 1'b0;
		req_ch.valid = 1'b0;
		req_ch.req_type = REQ_UNUSED;
		req_ch.row = '0;
		req_ch.col = '0;
		req_ch.value = '0;
		req_ch.random_fraction = '0;
		res_ch.ready = 1'b0;
		cfg_ch.valid = 1'b0;
		cfg_ch.index = CFG_LOC_COUNT;
		cfg_ch.data = '0;
		errors = 0;
		stall_cycles = 0;
		tx_idle = 15;
		rx_idle = 57;
		visited = '0;
		cur_loc = '0;
		loc_count = 7'd64;
		start_loc = 6'd0;
		finish_loc = 6'd1;
		nbr_count = 5'd8;
		tau_max = 32'd65536;
		tau_min = 32'd655;
		retain = 16'd52429;
		cur_req = mk(REQ_UNUSED, '0, '0, '0, '0);

		// every setting keeps the ant inside the loaded locations
		regs[0] = '{32'd16, 32'd3, 32'd5, 32'd8, 32'd65536, 32'd655, 32'd52429};
		regs[1] = '{32'd2, 32'd15, 32'd0, 32'd1, 32'hFFFF_FFFF, 32'd0, 32'hFFFF};
		regs[2] = '{32'd16, 32'd0, 32'd63, 32'd31, 32'd0, 32'hFFFF_FFFF, 32'd0};
		regs[3] = '{32'd16, 32'd10, 32'd20, 32'd16, 32'd200000, 32'd100, 32'd40000};
		regs[4] = '{32'd0, 32'd1, 32'd2, 32'd0, 32'd65536, 32'd0, 32'd0};

		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// limit the tour to the locations whose tables are loaded
		write_reg(CFG_LOC_COUNT, 32'(USED_LOCS));
		cfg_ch.valid <= 1'b0;
		@(negedge clk);

		// fill the heuristic and neighbour tables so nothing unwritten is read
		for (int r = 0; r < USED_LOCS; r++)
			for (int c = 0; c < USED_LOCS; c++)
				send(mk(REQ_LOAD_HEUR, 6'(r), 6'(c),
					($urandom_range(7) == 0) ? 32'd0 : $urandom, 16'($urandom)));
		for (int r = 0; r < USED_LOCS; r++)
			for (int s = 0; s < SLOTS; s++)
				send(mk(REQ_LOAD_NBR, 6'(r), 6'(s), 32'($urandom_range(0, 19)),
					16'($urandom)));

		// directed requests; fixed answers where they are obvious
		it = mk(REQ_UNUSED, 6'd63, 6'd63, 32'hFFFF_FFFF, 16'hFFFF);
		it.typed = 1'b1;
		directed = {directed, it};
		it = mk(REQ_INIT_PHER, '0, '0, '0, '0);
		it.typed = 1'b1;
		directed = {directed, it};
		it = mk(REQ_START_ANT, '0, '0, '0, '0);
		it.typed = 1'b1;
		directed = {directed, it};
		it = mk(REQ_LOAD_NBR, 6'd0, 6'd31, 32'd63, '0);
		it.typed = 1'b1;
		directed = {directed, it};
		directed = {directed, mk(REQ_STEP, '0, '0, '0, 16'd0)};
		directed = {directed, mk(REQ_STEP, '0, '0, '0, 16'hFFFF)};
		directed = {directed, mk(REQ_DEPOSIT, 6'd63, 6'd63, 32'hFFFF_FFFF, '0)};
		directed = {directed, mk(REQ_DEPOSIT, 6'd0, 6'd0, 32'd0, '0)};
		directed = {directed, mk(REQ_EVAPORATE, '0, '0, '0, '0)};
		directed = {directed, mk(REQ_LOAD_HEUR, 6'd63, 6'd63, 32'd0, '0)};
		directed = {directed, mk(REQ_LOAD_HEUR, 6'd0, 6'd0, 32'hFFFF_FFFF, '0)};
		for (int i = 0; i < 8; i++)
			directed = {directed, mk(REQ_STEP, '0, '0, '0, 16'($urandom))};
		foreach (directed[i])
			send(directed[i]);
		drain();

		// random tours, each phase under its own setting; idling set per phase
		for (int p = 0; p < PHASES; p++) begin
			drain();
			for (int i = 0; i < 7; i++)
				write_reg(3'(i), regs[p][i]);
			cfg_ch.valid <= 1'b0;
			tx_idle = (p == 0) ? 15 : (p == 1) ? 57 : 0;
			rx_idle = (p == 0) ? 57 : (p == 1) ? 15 : 0;
			@(negedge clk);
			send(mk(REQ_INIT_PHER, '0, '0, '0, '0));
			send(mk(REQ_START_ANT, '0, '0, '0, '0));
			for (int i = 0; i < PHASE_WORDS; i++)
				send(random_request());
		end
		drain();
		repeat (40) @(posedge clk);

		if (errors == 0)
			$display("tb_ant_colony_pheromone_step_unit: clean");
		else
			$display("tb_ant_colony_pheromone_step_unit: errors");
		$finish;
	end
endmodule
`default_nettype wire
